// ===== rtl/core/ssmg_pkg.sv =====
// Shared constants and types for the sound source motion generator.
package ssmg_pkg;

  localparam int TRACE_DEPTH_DEF = 256;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int LIMIT_W = 15;
  localparam int MODE_W  = 2;
  localparam int FUNC_W  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd4096;

  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_POS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_VEL = 3'd4;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic replay;
    logic rejected;
  } trace_status_t;

endpackage

// ===== rtl/core/ssmg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssmg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ssmg_trace.sv =====
// Trace store with fill count and replay index, updated as each word is accepted.
module ssmg_trace #(
  parameter int TRACE_DEPTH = ssmg_pkg::TRACE_DEPTH_DEF,
  parameter int COORD_WIDTH = ssmg_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 take,
  input  logic [ssmg_pkg::FUNC_W-1:0]          func,
  input  logic [ssmg_pkg::MODE_W-1:0]          mode,
  input  logic [3*COORD_WIDTH-1:0]             point,
  output ssmg_pkg::trace_status_t              status,
  output logic [$clog2(TRACE_DEPTH+1)-1:0]     count_nxt,
  output logic [3*COORD_WIDTH-1:0]             rd_data
);

  localparam int CNT_W = $clog2(TRACE_DEPTH + 1);
  localparam int IDX_W = $clog2(TRACE_DEPTH);

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_inc;
  logic             full;
  logic             do_replay;
  logic             do_push;
  logic             do_clear;

  assign full      = (count_r == CNT_W'(TRACE_DEPTH));
  assign do_replay = take && (func == ssmg_pkg::FUNC_TICK) &&
                     (mode == ssmg_pkg::MODE_REPLAY) && (count_r != '0);
  assign do_push   = take && (func == ssmg_pkg::FUNC_PUSH) && !full;
  assign do_clear  = take && (func == ssmg_pkg::FUNC_CLEAR);

  assign rd_idx = (CNT_W'(idx_r) >= count_r) ? '0 : idx_r;
  assign rd_inc = CNT_W'(rd_idx) + CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (do_clear) begin
      count_nxt = '0;
      idx_nxt   = '0;
    end else if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_replay) begin
      idx_nxt = (rd_inc == count_r) ? '0 : rd_inc[IDX_W-1:0];
    end
  end

  assign status.replay   = do_replay;
  assign status.rejected = (func == ssmg_pkg::FUNC_PUSH) && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  ssmg_ram #(
    .WIDTH(3 * COORD_WIDTH),
    .DEPTH(TRACE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(point),
    .re   (do_replay),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

endmodule

// ===== rtl/core/ssmg_axis.sv =====
// One axis of the bounce step: clamp to the box, reflect velocity, saturating add.
module ssmg_axis #(
  parameter int COORD_WIDTH = ssmg_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0]       pos,
  input  logic signed [COORD_WIDTH-1:0]       vel,
  input  logic        [ssmg_pkg::LIMIT_W-1:0] limit,
  output logic signed [COORD_WIDTH-1:0]       pos_nxt,
  output logic signed [COORD_WIDTH-1:0]       vel_nxt
);

  localparam int WW = ((COORD_WIDTH > ssmg_pkg::LIMIT_W) ? COORD_WIDTH
                                                         : ssmg_pkg::LIMIT_W) + 3;
  localparam logic signed [WW-1:0] HI = {{(WW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [WW-1:0] LO = ~HI;

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    if (v > HI) begin
      r = HI[COORD_WIDTH-1:0];
    end else if (v < LO) begin
      r = LO[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [WW-1:0]          pw;
  logic signed [WW-1:0]          vw;
  logic signed [WW-1:0]          lw;
  logic signed [WW-1:0]          p_abs;
  logic signed [COORD_WIDTH-1:0] pc;
  logic signed [WW-1:0]          pcw;
  logic signed [WW-1:0]          s;
  logic signed [WW-1:0]          s_abs;
  logic signed [COORD_WIDTH-1:0] vn;

  always_comb begin
    pw    = WW'(pos);
    vw    = WW'(vel);
    lw    = $signed(WW'(limit));
    p_abs = (pw < 0) ? -pw : pw;
    if (p_abs > lw) begin
      pc = (pw < 0) ? sat(-lw) : sat(lw);
    end else begin
      pc = pos;
    end
    pcw   = WW'(pc);
    s     = pcw + vw;
    s_abs = (s < 0) ? -s : s;
    vn    = (s_abs > lw) ? sat(-vw) : vel;
    pos_nxt = sat(pcw + WW'(vn));
    vel_nxt = vn;
  end

endmodule

// ===== rtl/core/sound_source_motion_generator.sv =====
// Top level of the sound source motion generator: item stage, state and result register.
//
// Usage: each input word carries a function code (tick, push trace point,
// clear trace, load position, load velocity) and a signed Q4.12 vector.
// Every accepted word yields exactly one result word: the position after
// the word, the number of stored trace points and a push-rejected flag.
// Words are accepted on in_valid and in_ready and results leave on
// out_valid and out_ready. The trace memory is read in the cycle a word
// is accepted, and all position arithmetic sits between the item register
// and the result register, which drives out_valid. Throughput is one word
// per cycle while the receiver keeps out_ready high.
// If the receiver stalls, the result register holds, the item register
// still takes one more word, and in_ready then drops until out_ready
// returns. Configuration writes (motion mode, bounce limit) are taken at
// any time on the cfg channel and must only be issued while idle.
// Reset clears position, velocity, trace count, replay index and sets the
// mode to hold and the limit to 1.0; trace contents are undefined until
// pushed, and no memory clearing pass is needed.
module sound_source_motion_generator #(
  parameter int TRACE_DEPTH = ssmg_pkg::TRACE_DEPTH_DEF,
  parameter int COORD_WIDTH = ssmg_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ssmg_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [COORD_WIDTH-1:0]        in_x,
  input  logic signed [COORD_WIDTH-1:0]        in_y,
  input  logic signed [COORD_WIDTH-1:0]        in_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_WIDTH-1:0]        out_pos_x,
  output logic signed [COORD_WIDTH-1:0]        out_pos_y,
  output logic signed [COORD_WIDTH-1:0]        out_pos_z,
  output logic [$clog2(TRACE_DEPTH+1)-1:0]     out_trace_count,
  output logic                                 out_push_rejected,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [ssmg_pkg::LIMIT_W-1:0]         cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(TRACE_DEPTH + 1);

  logic [ssmg_pkg::MODE_W-1:0]  mode_r;
  logic [ssmg_pkg::LIMIT_W-1:0] limit_r;

  logic                         s1_valid_r;
  logic [ssmg_pkg::FUNC_W-1:0]  s1_func_r;
  logic [3*CW-1:0]              s1_vec_r;
  ssmg_pkg::trace_status_t      s1_status_r;
  logic [CNT_W-1:0]             s1_count_r;

  logic                         out_valid_r;
  logic [CNT_W-1:0]             out_count_r;
  logic                         out_rejected_r;

  logic signed [CW-1:0] pos_r [3];
  logic signed [CW-1:0] vel_r [3];
  logic signed [CW-1:0] pos_nxt [3];
  logic signed [CW-1:0] vel_nxt [3];
  logic signed [CW-1:0] bpos [3];
  logic signed [CW-1:0] bvel [3];

  logic                    in_fire;
  logic                    s1_adv;
  logic                    s1_fire;
  ssmg_pkg::trace_status_t status;
  logic [CNT_W-1:0]        count_nxt;
  logic [3*CW-1:0]         rd_data;

  assign s1_adv    = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ssmg_pkg::MODE_HOLD;
      limit_r <= ssmg_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ssmg_pkg::CFG_MODE) begin
        mode_r <= cfg_data[ssmg_pkg::MODE_W-1:0];
      end else if (cfg_index == ssmg_pkg::CFG_LIMIT) begin
        limit_r <= cfg_data;
      end
    end
  end

  ssmg_trace #(
    .TRACE_DEPTH(TRACE_DEPTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_trace (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_fire),
    .func     (in_func),
    .mode     (mode_r),
    .point    ({in_z, in_y, in_x}),
    .status   (status),
    .count_nxt(count_nxt),
    .rd_data  (rd_data)
  );

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      ssmg_axis #(
        .COORD_WIDTH(COORD_WIDTH)
      ) u_axis (
        .pos    (pos_r[a]),
        .vel    (vel_r[a]),
        .limit  (limit_r),
        .pos_nxt(bpos[a]),
        .vel_nxt(bvel[a])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      vel_nxt[i] = vel_r[i];
    end
    case (s1_func_r)
      ssmg_pkg::FUNC_TICK: begin
        if (s1_status_r.replay) begin
          for (int i = 0; i < 3; i++) begin
            pos_nxt[i] = rd_data[i*CW +: CW];
          end
        end else if (mode_r == ssmg_pkg::MODE_BOUNCE) begin
          for (int i = 0; i < 3; i++) begin
            pos_nxt[i] = bpos[i];
            vel_nxt[i] = bvel[i];
          end
        end
      end
      ssmg_pkg::FUNC_LOAD_POS: begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = s1_vec_r[i*CW +: CW];
        end
      end
      ssmg_pkg::FUNC_LOAD_VEL: begin
        for (int i = 0; i < 3; i++) begin
          vel_nxt[i] = s1_vec_r[i*CW +: CW];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= pos_nxt[i];
          vel_r[i] <= vel_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r   <= in_func;
      s1_vec_r    <= {in_z, in_y, in_x};
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
    end
    if (s1_fire) begin
      out_count_r    <= s1_count_r;
      out_rejected_r <= s1_status_r.rejected;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = pos_r[0];
  assign out_pos_y         = pos_r[1];
  assign out_pos_z         = pos_r[2];
  assign out_trace_count   = out_count_r;
  assign out_push_rejected = out_rejected_r;

`ifndef ASSERT_OFF
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_rejected) |-> (out_trace_count == CNT_W'(TRACE_DEPTH)))
    else $error("push rejected while trace not full");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_ready)
    else $error("word accepted while item stage is stalled");

  a_replay_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_status_r.replay) |=> (out_pos_x == $past(rd_data[CW-1:0])))
    else $error("replayed point not loaded into position");
`endif

endmodule
